// ----- rtl/dgtc_pkg.sv -----
// Shared constants, tables and register codes for the go-to-goal drive controller.
package dgtc_pkg;

   localparam int DefCordicStages = 16;
   localparam int TabLen          = 24;

   // Angle words carry 2^32 units per turn, vector words carry Q16 millimetres.
   localparam int AngW = 34;
   localparam int VecW = 36;

   localparam logic signed [AngW-1:0] QuarterTurn = 34'sd1073741824;
   localparam logic signed [AngW-1:0] HalfTurn    = 34'sd2147483648;

   localparam logic signed [16:0] KinvS     = 17'sd39797;
   localparam logic signed [29:0] MradMulS  = 30'sd411774815;
   localparam logic [14:0]        FwdScale  = 15'd25600;
   localparam logic [14:0]        TurnScale = 15'd19200;

   // Wheel terms never exceed 25600, so fifteen quotient bits suffice.
   localparam int DivQuotW = 15;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FORWARD_GAIN  = 3'd0,
      CSR_FORWARD_LIMIT = 3'd1,
      CSR_TURN_GAIN     = 3'd2,
      CSR_TURN_LIMIT    = 3'd3,
      CSR_DEADBAND      = 3'd4
   } csr_index_type;

   localparam logic [CsrDataW-1:0] RstForwardGain  = 16'd256;
   localparam logic [CsrDataW-1:0] RstForwardLimit = 16'd300;
   localparam logic [CsrDataW-1:0] RstTurnGain     = 16'd256;
   localparam logic [CsrDataW-1:0] RstTurnLimit    = 16'd1000;
   localparam logic [CsrDataW-1:0] RstDeadband     = 16'd100;

   localparam logic [31:0] AtanTab [TabLen] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

endpackage

// ----- rtl/dgtc_div_stage.sv -----
// One restoring step of the pipelined wheel-term divider.
module dgtc_div_stage #(
   parameter int RemW  = 56,
   parameter int DivW  = 40,
   parameter int QW    = 15,
   parameter int Shift = 14
) (
   input  logic            clock,
   input  logic            load,
   input  logic [RemW-1:0] rem_in,
   input  logic [DivW-1:0] divisor,
   input  logic [QW-1:0]   quot_in,
   output logic [RemW-1:0] rem_out,
   output logic [QW-1:0]   quot_out
);

   logic [RemW-1:0] dsh;
   logic            take;
   logic [RemW-1:0] rem_ff;
   logic [QW-1:0]   quot_ff;

   assign dsh  = RemW'(divisor) << Shift;
   assign take = (rem_in >= dsh);

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= take ? (rem_in - dsh) : rem_in;
         quot_ff <= {quot_in[QW-2:0], take};
      end
   end

   assign rem_out  = rem_ff;
   assign quot_out = quot_ff;

endmodule

// ----- rtl/diff_drive_goal_tracking_controller.sv -----
// Top level of the differential-drive go-to-goal controller pipeline.
//
// Usage: each input word on the req_ channel carries one robot's goal, its
// measured position in millimetres and its heading as a 16-bit binary angle,
// with the robot index in req_tuser. For each word the block returns one word
// on the rsp_ channel holding the two wheel commands in 1/256 percent and the
// echoed robot index in rsp_tuser.
// Gains, limits and the deadband are written through the csr_ port while no
// word is in flight; gains and limits take effect in the cycle after the write,
// the deadband only once its square, registered behind it, has been updated.
// The pipeline holds three setup stages, the rotation CORDIC chain, the
// vectoring setup stage, the vectoring CORDIC chain, four scaling stages,
// a fifteen-step restoring divider and the output register.
// Throughput is one word per cycle while rsp_tready is high; every stage
// holds a word and a valid bit. A stall on rsp_tready only holds the stages
// that are full up to the first bubble, so the pipe keeps taking words until
// it has filled completely. Reset clears every valid bit and loads the
// register reset values; no word is lost or repeated across a stall.
module diff_drive_goal_tracking_controller
   import dgtc_pkg::*;
#(
   parameter int CORDIC_STAGES = DefCordicStages
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // goal_x_mm [15:0], goal_y_mm [31:16], pos_x_mm [47:32], pos_y_mm [63:48],
   // heading [79:64]
   input  logic [79:0]         req_tdata,
   // robot_index [3:0]
   input  logic [3:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // first_wheel_cmd [16:0], second_wheel_cmd [33:17], zero fill [39:34]
   output logic [39:0]         rsp_tdata,
   // robot_out [3:0]
   output logic [3:0]          rsp_tuser,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam int NS    = CORDIC_STAGES;
   localparam int StA   = 0;
   localparam int StB   = 1;
   localparam int StC   = 2;
   localparam int StR0  = 3;
   localparam int StV   = 3 + NS;
   localparam int StQ0  = 4 + NS;
   localparam int StM1  = 4 + 2 * NS;
   localparam int StM2  = 5 + 2 * NS;
   localparam int StM3  = 6 + 2 * NS;
   localparam int StM4  = 7 + 2 * NS;
   localparam int StD0  = 8 + 2 * NS;
   localparam int StF   = StD0 + DivQuotW;
   localparam int P     = StF + 1;
   localparam int FRemW = 56;
   localparam int TRemW = 48;

   // Configuration registers. The deadband square is kept precomputed.
   logic [CsrDataW-1:0] fwd_gain_ff, fwd_lim_ff, turn_gain_ff, turn_lim_ff, deadband_ff;
   logic [31:0]         db_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_gain_ff  <= RstForwardGain;
         fwd_lim_ff   <= RstForwardLimit;
         turn_gain_ff <= RstTurnGain;
         turn_lim_ff  <= RstTurnLimit;
         deadband_ff  <= RstDeadband;
         db_sq_ff     <= RstDeadband * RstDeadband;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_FORWARD_GAIN:  fwd_gain_ff  <= csr_wdata;
               CSR_FORWARD_LIMIT: fwd_lim_ff   <= csr_wdata;
               CSR_TURN_GAIN:     turn_gain_ff <= csr_wdata;
               CSR_TURN_LIMIT:    turn_lim_ff  <= csr_wdata;
               CSR_DEADBAND:      deadband_ff  <= csr_wdata;
               default: ;
            endcase
         end
         db_sq_ff <= deadband_ff * deadband_ff;
      end
   end

   // Stage valid bits. A stage may load when it is empty or when the stage
   // after it loads in the same cycle.
   logic [P-1:0] vld_ff;
   logic [P-1:0] vld_in;
   logic [P:0]   adv;

   assign adv[P]  = rsp_tready;
   assign vld_in  = {vld_ff[P-2:0], req_tvalid};

   for (genvar s = 0; s < P; s++) begin : g_adv
      assign adv[s] = ~vld_ff[s] | adv[s+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < P; s++) begin
            if (adv[s]) begin
               vld_ff[s] <= vld_in[s];
            end
         end
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[P-1];

   // The robot index rides along every stage.
   logic [3:0] rob_ff [P];

   for (genvar s = 0; s < P; s++) begin : g_rob
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            rob_ff[s] <= (s == 0) ? req_tuser : rob_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   // Stage A: position error.
   logic signed [15:0] goal_x, goal_y, pos_x, pos_y, head;
   logic signed [16:0] a_dx_ff, a_dy_ff;
   logic signed [15:0] a_hd_ff;

   assign goal_x = req_tdata[15:0];
   assign goal_y = req_tdata[31:16];
   assign pos_x  = req_tdata[47:32];
   assign pos_y  = req_tdata[63:48];
   assign head   = req_tdata[79:64];

   always_ff @(posedge clock) begin
      if (adv[StA]) begin
         a_dx_ff <= {goal_x[15], goal_x} - {pos_x[15], pos_x};
         a_dy_ff <= {goal_y[15], goal_y} - {pos_y[15], pos_y};
         a_hd_ff <= head;
      end
   end

   // Stage B: squares for the deadband test and the CORDIC gain prescale.
   logic signed [33:0] sqx, sqy, bx34, by34;
   logic [31:0]        b_sqx_ff, b_sqy_ff;
   logic signed [VecW-1:0] b_x_ff, b_y_ff;
   logic signed [15:0] b_hd_ff;

   assign sqx  = a_dx_ff * a_dx_ff;
   assign sqy  = a_dy_ff * a_dy_ff;
   assign bx34 = a_dx_ff * KinvS;
   assign by34 = a_dy_ff * KinvS;

   always_ff @(posedge clock) begin
      if (adv[StB]) begin
         b_sqx_ff <= sqx[31:0];
         b_sqy_ff <= sqy[31:0];
         b_x_ff   <= {{(VecW-34){bx34[33]}}, bx34};
         b_y_ff   <= {{(VecW-34){by34[33]}}, by34};
         b_hd_ff  <= a_hd_ff;
      end
   end

   // Stage C: deadband compare and quadrant fold of the rotation angle.
   logic signed [VecW-1:0] rx_ff [NS+1];
   logic signed [VecW-1:0] ry_ff [NS+1];
   logic signed [AngW-1:0] rz_ff [NS+1];
   logic                   rout_ff [NS+1];
   logic [32:0]            c_sum;
   logic signed [AngW-1:0] c_zh, c_z0;

   assign c_sum = {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};
   assign c_zh  = {{(AngW-32){b_hd_ff[15]}}, b_hd_ff, 16'b0};
   assign c_z0  = -c_zh;

   always_ff @(posedge clock) begin
      if (adv[StC]) begin
         rout_ff[0] <= (c_sum > {1'b0, db_sq_ff});
         if (c_z0 > QuarterTurn) begin
            rx_ff[0] <= -b_x_ff;
            ry_ff[0] <= -b_y_ff;
            rz_ff[0] <= c_z0 - HalfTurn;
         end else if (c_z0 < -QuarterTurn) begin
            rx_ff[0] <= -b_x_ff;
            ry_ff[0] <= -b_y_ff;
            rz_ff[0] <= c_z0 + HalfTurn;
         end else begin
            rx_ff[0] <= b_x_ff;
            ry_ff[0] <= b_y_ff;
            rz_ff[0] <= c_z0;
         end
      end
   end

   // Rotation CORDIC: turns the error into the body frame.
   for (genvar i = 0; i < NS; i++) begin : g_rot
      localparam logic signed [AngW-1:0] Ang = {{(AngW-32){1'b0}}, AtanTab[i]};
      always_ff @(posedge clock) begin
         if (adv[StR0+i]) begin
            rout_ff[i+1] <= rout_ff[i];
            if (!rz_ff[i][AngW-1]) begin
               rx_ff[i+1] <= rx_ff[i] - (ry_ff[i] >>> i);
               ry_ff[i+1] <= ry_ff[i] + (rx_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] - Ang;
            end else begin
               rx_ff[i+1] <= rx_ff[i] + (ry_ff[i] >>> i);
               ry_ff[i+1] <= ry_ff[i] - (rx_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] + Ang;
            end
         end
      end
   end

   // Stage V: vectoring setup. Left half-plane vectors are turned a quarter.
   logic signed [VecW-1:0] vx_ff [NS+1];
   logic signed [VecW-1:0] vy_ff [NS+1];
   logic signed [AngW-1:0] vz_ff [NS+1];
   logic signed [VecW-1:0] vbx_ff [NS+1];
   logic                   vout_ff [NS+1];
   logic                   vzero_ff [NS+1];

   always_ff @(posedge clock) begin
      if (adv[StV]) begin
         vbx_ff[0]   <= rx_ff[NS];
         vout_ff[0]  <= rout_ff[NS];
         vzero_ff[0] <= (rx_ff[NS] == '0) && (ry_ff[NS] == '0);
         if (rx_ff[NS][VecW-1]) begin
            if (!ry_ff[NS][VecW-1]) begin
               vx_ff[0] <= ry_ff[NS];
               vy_ff[0] <= -rx_ff[NS];
               vz_ff[0] <= QuarterTurn;
            end else begin
               vx_ff[0] <= -ry_ff[NS];
               vy_ff[0] <= rx_ff[NS];
               vz_ff[0] <= -QuarterTurn;
            end
         end else begin
            vx_ff[0] <= rx_ff[NS];
            vy_ff[0] <= ry_ff[NS];
            vz_ff[0] <= '0;
         end
      end
   end

   // Vectoring CORDIC: accumulates the bearing of the body-frame error.
   for (genvar i = 0; i < NS; i++) begin : g_vec
      localparam logic signed [AngW-1:0] Ang = {{(AngW-32){1'b0}}, AtanTab[i]};
      always_ff @(posedge clock) begin
         if (adv[StQ0+i]) begin
            vbx_ff[i+1]   <= vbx_ff[i];
            vout_ff[i+1]  <= vout_ff[i];
            vzero_ff[i+1] <= vzero_ff[i];
            if (!vy_ff[i][VecW-1]) begin
               vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] + Ang;
            end else begin
               vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] - Ang;
            end
         end
      end
   end

   // Stage M1: bearing to milliradians (Q48 product, rounded to Q8 in M2) and raw forward drive (Q24).
   logic signed [AngW-1:0] m1_z;
   logic signed [63:0]     m1_mp, m1_mp_ff;
   logic signed [16:0]     fgain_s, tgain_s;
   logic signed [52:0]     m1_fwd, m1_fwd_ff;
   logic                   m1_out_ff;

   assign m1_z    = vzero_ff[NS] ? '0 : vz_ff[NS];
   assign m1_mp   = m1_z * MradMulS;
   assign fgain_s = {1'b0, fwd_gain_ff};
   assign tgain_s = {1'b0, turn_gain_ff};
   assign m1_fwd  = fgain_s * vbx_ff[NS];

   always_ff @(posedge clock) begin
      if (adv[StM1]) begin
         m1_mp_ff  <= m1_mp;
         m1_fwd_ff <= m1_fwd;
         m1_out_ff <= vout_ff[NS];
      end
   end

   // Stage M2: round the bearing, raw turn drive, clamp forward drive.
   logic signed [63:0] m2_mr;
   logic signed [23:0] m2_mrad;
   logic signed [40:0] m2_turn;
   logic signed [52:0] m2_flim;
   logic [39:0]        m2_fwd_ff;
   logic signed [40:0] m2_turn_ff;
   logic               m2_out_ff;

   assign m2_mr   = m1_mp_ff + 64'sd549755813888;
   assign m2_mrad = m2_mr[63:40];
   assign m2_turn = tgain_s * m2_mrad;
   assign m2_flim = {13'b0, fwd_lim_ff, 24'b0};

   always_ff @(posedge clock) begin
      if (adv[StM2]) begin
         m2_out_ff  <= m1_out_ff;
         m2_turn_ff <= m2_turn;
         if (!m1_out_ff || m1_fwd_ff[52]) begin
            m2_fwd_ff <= '0;
         end else if (m1_fwd_ff > m2_flim) begin
            m2_fwd_ff <= m2_flim[39:0];
         end else begin
            m2_fwd_ff <= m1_fwd_ff[39:0];
         end
      end
   end

   // Stage M3: clamp turn drive to its magnitude and sign; forward numerator.
   logic signed [40:0] m3_tlim;
   logic signed [40:0] m3_turn;
   logic [55:0]        m3_fnum;
   logic [55:0]        m3_fnum_ff;
   logic [31:0]        m3_tmag_ff;
   logic               m3_tneg_ff;

   assign m3_tlim = {9'b0, turn_lim_ff, 16'b0};
   assign m3_fnum = (56'(m2_fwd_ff) * 56'(FwdScale)) + {9'b0, fwd_lim_ff, 23'b0};

   always_comb begin
      if (!m2_out_ff) begin
         m3_turn = '0;
      end else if (m2_turn_ff > m3_tlim) begin
         m3_turn = m3_tlim;
      end else if (m2_turn_ff < -m3_tlim) begin
         m3_turn = -m3_tlim;
      end else begin
         m3_turn = m2_turn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[StM3]) begin
         m3_fnum_ff <= m3_fnum;
         m3_tneg_ff <= m3_turn[40];
         m3_tmag_ff <= m3_turn[40] ? 32'(-m3_turn) : m3_turn[31:0];
      end
   end

   // Stage M4: turn numerator with the half-divisor added for rounding.
   logic [TRemW-1:0] m4_tnum;
   logic [FRemW-1:0] m4_fnum_ff;
   logic [TRemW-1:0] m4_tnum_ff;
   logic             m4_tneg_ff;

   assign m4_tnum = (TRemW'(m3_tmag_ff) * TRemW'(TurnScale)) + {17'b0, turn_lim_ff, 15'b0};

   always_ff @(posedge clock) begin
      if (adv[StM4]) begin
         m4_fnum_ff <= m3_fnum_ff;
         m4_tnum_ff <= m4_tnum;
         m4_tneg_ff <= m3_tneg_ff;
      end
   end

   // Divider: one quotient bit per stage for both wheel terms.
   logic [FRemW-1:0]    frem  [DivQuotW+1];
   logic [DivQuotW-1:0] fquot [DivQuotW+1];
   logic [TRemW-1:0]    trem  [DivQuotW+1];
   logic [DivQuotW-1:0] tquot [DivQuotW+1];
   logic                dneg_ff [DivQuotW+1];
   logic [39:0]         fdiv;
   logic [31:0]         tdiv;

   assign fdiv     = {fwd_lim_ff, 24'b0};
   assign tdiv     = {turn_lim_ff, 16'b0};
   assign frem[0]  = m4_fnum_ff;
   assign fquot[0] = '0;
   assign trem[0]  = m4_tnum_ff;
   assign tquot[0] = '0;

   always_comb dneg_ff[0] = m4_tneg_ff;

   for (genvar k = 0; k < DivQuotW; k++) begin : g_div
      dgtc_div_stage #(
         .RemW(FRemW), .DivW(40), .QW(DivQuotW), .Shift(DivQuotW - 1 - k)
      ) u_fdiv (
         .clock(clock), .load(adv[StD0+k]), .rem_in(frem[k]), .divisor(fdiv),
         .quot_in(fquot[k]), .rem_out(frem[k+1]), .quot_out(fquot[k+1])
      );
      dgtc_div_stage #(
         .RemW(TRemW), .DivW(32), .QW(DivQuotW), .Shift(DivQuotW - 1 - k)
      ) u_tdiv (
         .clock(clock), .load(adv[StD0+k]), .rem_in(trem[k]), .divisor(tdiv),
         .quot_in(tquot[k]), .rem_out(trem[k+1]), .quot_out(tquot[k+1])
      );
      always_ff @(posedge clock) begin
         if (adv[StD0+k]) begin
            dneg_ff[k+1] <= dneg_ff[k];
         end
      end
   end

   // Output stage: a zero limit gives a zero term; combine into wheel commands.
   logic signed [16:0] f_term, t_mag, t_term;
   logic signed [16:0] first_ff, second_ff;

   assign f_term = (fwd_lim_ff == '0) ? '0 : {2'b0, fquot[DivQuotW]};
   assign t_mag  = (turn_lim_ff == '0) ? '0 : {2'b0, tquot[DivQuotW]};
   assign t_term = dneg_ff[DivQuotW] ? -t_mag : t_mag;

   always_ff @(posedge clock) begin
      if (adv[StF]) begin
         first_ff  <= f_term + t_term;
         second_ff <= f_term - t_term;
      end
   end

   assign rsp_tdata = {6'b0, second_ff, first_ff};
   assign rsp_tuser = rob_ff[P-1];

endmodule

// ----- verif/diff_drive_goal_tracking_controller_tb.sv -----
// Self-checking testbench for the differential-drive go-to-goal controller.
`timescale 1ns / 100ps

// Tracks the wheel commands that each accepted sample should produce.
class wheel_cmd_scoreboard;
   logic [3:0]  exp_robot[1024];
   logic [16:0] exp_first[1024];
   logic [16:0] exp_second[1024];
   logic [9:0]  wr_idx;
   logic [9:0]  rd_idx;
   int          count;
   int          errors;

   function new();
      errors = 0;
      wr_idx = '0;
      rd_idx = '0;
      count  = 0;
   endfunction

   function void note_sample(logic [3:0] robot, logic [16:0] first, logic [16:0] second);
      exp_robot[wr_idx]  = robot;
      exp_first[wr_idx]  = first;
      exp_second[wr_idx] = second;
      wr_idx = wr_idx + 10'd1;
      count++;
   endfunction

   function void check_word(logic [3:0] robot, logic [39:0] data);
      logic [3:0]  r;
      logic [16:0] f;
      logic [16:0] s;
      if (count == 0) begin
         $display("%0t: unexpected result word, robot %0d data %h", $time, robot, data);
         errors++;
         return;
      end
      r = exp_robot[rd_idx];
      f = exp_first[rd_idx];
      s = exp_second[rd_idx];
      rd_idx = rd_idx + 10'd1;
      count--;
      if (robot !== r) begin
         $display("%0t: robot_out expected %0d actual %0d", $time, r, robot);
         errors++;
      end
      if (data[16:0] !== f) begin
         $display("%0t: first_wheel_cmd expected %0d actual %0d", $time,
                  $signed(f), $signed(data[16:0]));
         errors++;
      end
      if (data[33:17] !== s) begin
         $display("%0t: second_wheel_cmd expected %0d actual %0d", $time,
                  $signed(s), $signed(data[33:17]));
         errors++;
      end
      if (data[39:34] !== 6'd0) begin
         $display("%0t: zero fill expected 0 actual %h", $time, data[39:34]);
         errors++;
      end
   endfunction

   function int pending();
      return count;
   endfunction
endclass

module diff_drive_goal_tracking_controller_tb;
   import dgtc_pkg::*;

   localparam int Stages   = DefCordicStages;
   localparam int Latency  = 2 * Stages + 24;
   localparam int CycleCap = 400000;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   // goal_x_mm, goal_y_mm, pos_x_mm, pos_y_mm, heading from the lowest bit up
   logic [79:0]         req_tdata;
   // robot_index
   logic [3:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // first_wheel_cmd, second_wheel_cmd, zero fill
   logic [39:0]         rsp_tdata;
   // robot_out
   logic [3:0]          rsp_tuser;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   // The predictor's copy of the control registers.
   logic [15:0] gain_fwd, limit_fwd, gain_turn, limit_turn, deadband;

   wheel_cmd_scoreboard sb;
   int  cycle_count;
   bit  stall_mode;

   diff_drive_goal_tracking_controller #(.CORDIC_STAGES(Stages)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Arithmetic shift right that floors, as the pipeline does.
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_div(longint n, longint d);
      longint mag;
      longint q;
      if (d == 0) return 0;
      mag = (n < 0) ? -n : n;
      q = (mag + d / 2) / d;
      return (n < 0) ? -q : q;
   endfunction

   // Works out both wheel commands for one sample under the current registers.
   function automatic void predict_wheels(logic [79:0] d, output logic [16:0] first,
                                          output logic [16:0] second);
      longint dx, dy, head, bx, by, x, y, z, t, mrad, fwd, turn, flim, tlim;
      longint fterm, tterm, db;
      int stg;
      stg = (Stages < TabLen) ? Stages : TabLen;
      dx = longint'($signed(d[15:0])) - longint'($signed(d[47:32]));
      dy = longint'($signed(d[31:16])) - longint'($signed(d[63:48]));
      head = longint'($signed(d[79:64]));
      db = longint'(deadband);
      fwd = 0;
      turn = 0;
      if (dx * dx + dy * dy > db * db) begin
         flim = longint'(limit_fwd) * 16777216;
         tlim = longint'(limit_turn) * 65536;
         // Rotate the world-frame error into the body frame.
         x = dx * 39797;
         y = dy * 39797;
         z = -(head * 65536);
         if (z > 64'sd1073741824) begin
            x = -x; y = -y; z -= 64'sd2147483648;
         end else if (z < -64'sd1073741824) begin
            x = -x; y = -y; z += 64'sd2147483648;
         end
         for (int i = 0; i < stg; i++) begin
            if (z >= 0) begin
               t = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= longint'(AtanTab[i]);
            end else begin
               t = x + shr_floor(y, i); y = y - shr_floor(x, i); z += longint'(AtanTab[i]);
            end
            x = t;
         end
         bx = x;
         by = y;
         // Bearing of the body-frame vector; a zero vector has zero bearing.
         z = 0;
         if (!(x == 0 && y == 0)) begin
            if (x < 0) begin
               if (y >= 0) begin
                  t = y; y = -x; x = t; z = 64'sd1073741824;
               end else begin
                  t = -y; y = x; x = t; z = -64'sd1073741824;
               end
            end
            for (int i = 0; i < stg; i++) begin
               if (y >= 0) begin
                  t = x + shr_floor(y, i); y = y - shr_floor(x, i); z += longint'(AtanTab[i]);
               end else begin
                  t = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= longint'(AtanTab[i]);
               end
               x = t;
            end
         end
         fwd = longint'(gain_fwd) * bx;
         if (fwd > flim) fwd = flim;
         if (fwd < -flim) fwd = -flim;
         mrad = shr_floor(z * 411774815 + (64'sd1 <<< 39), 40);
         turn = longint'(gain_turn) * mrad;
         if (turn > tlim) turn = tlim;
         if (turn < -tlim) turn = -tlim;
      end
      if (fwd < 0) fwd = 0;
      fterm = round_div(fwd * 25600, longint'(limit_fwd) <<< 24);
      tterm = round_div(turn * 19200, longint'(limit_turn) <<< 16);
      first = 17'(fterm + tterm);
      second = 17'(fterm - tterm);
   endfunction

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FORWARD_GAIN:  gain_fwd = value;
         CSR_FORWARD_LIMIT: limit_fwd = value;
         CSR_TURN_GAIN:     gain_turn = value;
         CSR_TURN_LIMIT:    limit_turn = value;
         default:           deadband = value;
      endcase
   endtask

   task automatic load_settings(logic [15:0] fg, logic [15:0] fl, logic [15:0] tg,
                                logic [15:0] tl, logic [15:0] db);
      write_reg(CSR_FORWARD_GAIN, fg);
      write_reg(CSR_FORWARD_LIMIT, fl);
      write_reg(CSR_TURN_GAIN, tg);
      write_reg(CSR_TURN_LIMIT, tl);
      write_reg(CSR_DEADBAND, db);
      @(posedge clock);
   endtask

   // Presents one sample and holds it until the block takes it. The valid stays
   // high after acceptance; the caller lowers it when a gap follows.
   task automatic send_sample(logic [3:0] robot, logic [79:0] data);
      logic [16:0] f, s;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= robot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_wheels(data, f, s);
      sb.note_sample(robot, f, s);
   endtask

   task automatic idle_gap(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      idle_gap(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (Latency + 8) @(posedge clock);
   endtask

   function automatic logic [79:0] pack(logic [15:0] gx, logic [15:0] gy, logic [15:0] px,
                                        logic [15:0] py, logic [15:0] hd);
      return {hd, py, px, gy, gx};
   endfunction

   // Mostly moderate distances so the drives stay between the clamps; some
   // samples use raw full-range fields so every bit toggles.
   function automatic logic [79:0] random_sample();
      logic [15:0] gx, gy, px, py;
      int unsigned sel;
      sel = $urandom_range(0, 9);
      px = 16'($urandom);
      py = 16'($urandom);
      if (sel < 3) begin
         gx = 16'($urandom);
         gy = 16'($urandom);
      end else if (sel < 5) begin
         gx = px + 16'($urandom_range(0, 300)) - 16'd150;
         gy = py + 16'($urandom_range(0, 300)) - 16'd150;
      end else begin
         gx = px + 16'($urandom_range(0, 4000)) - 16'd2000;
         gy = py + 16'($urandom_range(0, 4000)) - 16'd2000;
      end
      return pack(gx, gy, px, py, 16'($urandom));
   endfunction

   task automatic random_burst_run(int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_sample(4'($urandom), random_sample());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      end
   endtask

   // Receiver stall pattern: alternates between always-ready stretches and
   // stretches with random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
         rsp_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
   end

   // Results are checked at the edge where they are accepted.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tuser, rsp_tdata);
   end

   // Watchdog: the whole run is far shorter than this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleCap) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = CSR_FORWARD_GAIN;
      csr_wdata = '0;
      gain_fwd = RstForwardGain;
      limit_fwd = RstForwardLimit;
      gain_turn = RstTurnGain;
      limit_turn = RstTurnLimit;
      deadband = RstDeadband;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed samples at reset settings: zero error, inside and on the
      // deadband edge, each heading quadrant, and the field extremes.
      send_sample(4'd0, pack(16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_sample(4'd15, pack(16'd100, 16'd0, 16'd0, 16'd0, 16'd0));
      send_sample(4'd1, pack(16'd101, 16'd0, 16'd0, 16'd0, 16'd0));
      send_sample(4'd2, pack(16'd1000, 16'd0, 16'd0, 16'd0, 16'h4000));
      send_sample(4'd3, pack(16'd1000, 16'd0, 16'd0, 16'd0, 16'hC000));
      send_sample(4'd4, pack(16'd1000, 16'd0, 16'd0, 16'd0, 16'h8000));
      send_sample(4'd5, pack(16'd0, 16'hFC18, 16'd0, 16'd0, 16'h7FFF));
      send_sample(4'd6, pack(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000));
      send_sample(4'd7, pack(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
      send_sample(4'd8, pack(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h2000));
      send_sample(4'd9, pack(16'd50, 16'd0, 16'd0, 16'd0, 16'd0));
      send_sample(4'd10, pack(16'hFF9C, 16'd5, 16'd0, 16'd0, 16'd0));
      drain();

      // Extreme settings: zero gains and deadband, then maximal gains with
      // the smallest limits, then a huge deadband.
      load_settings(16'd0, 16'd1, 16'd0, 16'd1, 16'd0);
      send_sample(4'd1, pack(16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_sample(4'd2, pack(16'd1, 16'd1, 16'd0, 16'd0, 16'd0));
      random_burst_run(40);
      drain();
      load_settings(16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'd0);
      send_sample(4'd3, pack(16'd1, 16'd0, 16'd0, 16'd0, 16'd0));
      random_burst_run(60);
      drain();
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(4'd4, pack(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'd0));
      random_burst_run(60);
      drain();

      // Random settings phases.
      for (int ph = 0; ph < 6; ph++) begin
         load_settings(16'($urandom_range(0, 2048)), 16'($urandom_range(1, 65535)),
                       16'($urandom_range(0, 4096)), 16'($urandom_range(1, 65535)),
                       16'($urandom_range(0, 500)));
         random_burst_run(70);
         drain();
      end
      load_settings(RstForwardGain, RstForwardLimit, RstTurnGain, RstTurnLimit, RstDeadband);
      random_burst_run(150);
      drain();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ----- diff_drive_goal_tracking_controller.f -----
rtl/dgtc_pkg.sv
rtl/dgtc_div_stage.sv
rtl/diff_drive_goal_tracking_controller.sv
verif/diff_drive_goal_tracking_controller_tb.sv
